// ===== rtl/core/tun_pkg.sv =====
// shared widths and types for the triangle unit normal pipeline
`default_nettype none
package tun_pkg;

  localparam int CoordW         = 32;
  localparam int EdgeW          = CoordW + 1;
  localparam int ProdW          = 2 * EdgeW;
  localparam int CrossW         = ProdW + 1;
  localparam int MagW           = ProdW;
  localparam int HalfW          = MagW / 2;
  localparam int SqW            = 2 * MagW;
  localparam int SumW           = SqW + 2;
  localparam int NormalFracBits = 30;
  localparam int MW             = NormalFracBits + 1;
  localparam int OutW           = 32;
  localparam int AccW           = SumW + 2 * NormalFracBits + 6;
  localparam int TargetShift    = 2 * NormalFracBits + 2;
  localparam int InitAShift     = NormalFracBits + 2;
  localparam int NumSteps       = MW;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tun_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/triangle_unit_normal.sv =====
// top level of the triangle unit normal pipeline
// usage:
//   raise start_i with the three vertices (signed Q16.16) on the input ports;
//   the transfer happens at a clock edge with start_i high and busy_o low.
//   busy_o stays low, so a new face can be taken in every cycle.
//   each result shows on normal_*_o and degenerate_o for one cycle, marked by
//   valid_o; the receiver cannot stall.
//   stages: edge and cross product stages, squaring and sum stages,
//   31 digit stages (one per bit of the Q1.30 magnitude), 1 output register.
//   throughput: one face per cycle, set by the fully pipelined digit stages.
//   normal is round(c / |c|) in Q1.30, ties away from zero.
//   a zero cross product gives a zero normal with degenerate_o high.
//   reset clears only the valid and control bits; items in flight are dropped.
`default_nettype none
module triangle_unit_normal import tun_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic signed [CoordW-1:0] first_x_i,
  input  wire logic signed [CoordW-1:0] first_y_i,
  input  wire logic signed [CoordW-1:0] first_z_i,
  input  wire logic signed [CoordW-1:0] second_x_i,
  input  wire logic signed [CoordW-1:0] second_y_i,
  input  wire logic signed [CoordW-1:0] second_z_i,
  input  wire logic signed [CoordW-1:0] third_x_i,
  input  wire logic signed [CoordW-1:0] third_y_i,
  input  wire logic signed [CoordW-1:0] third_z_i,
  output logic                          valid_o,
  output logic signed [OutW-1:0]        normal_x_o,
  output logic signed [OutW-1:0]        normal_y_o,
  output logic signed [OutW-1:0]        normal_z_o,
  output logic                          degenerate_o
);

  tun_ctrl_t cross_ctrl, sq_ctrl;
  logic [MagW-1:0] mag_w [3];
  logic signed [AccW-1:0] r_w [NumSteps+1][3];
  logic signed [AccW-1:0] a_w [NumSteps+1][3];
  logic signed [AccW-1:0] b_w [NumSteps+1][3];
  logic [MW-1:0] m_w [NumSteps+1][3];
  tun_ctrl_t ctrl_q [NumSteps+1];
  logic signed [OutW-1:0] nrm_d [3];
  logic signed [OutW-1:0] nrm_q [3];
  logic valid_q, degen_q;

  assign busy_o = 1'b0;

  tun_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .ax_i    (first_x_i),
    .ay_i    (first_y_i),
    .az_i    (first_z_i),
    .bx_i    (second_x_i),
    .by_i    (second_y_i),
    .bz_i    (second_z_i),
    .cx_i    (third_x_i),
    .cy_i    (third_y_i),
    .cz_i    (third_z_i),
    .ctrl_o  (cross_ctrl),
    .mag_x_o (mag_w[0]),
    .mag_y_o (mag_w[1]),
    .mag_z_o (mag_w[2])
  );

  tun_square u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cross_ctrl),
    .mag_i  (mag_w),
    .ctrl_o (sq_ctrl),
    .r_o    (r_w[0]),
    .a_o    (a_w[0]),
    .b_o    (b_w[0])
  );

  assign ctrl_q[0] = sq_ctrl;

  for (genvar c = 0; c < 3; c++) begin : g_init
    assign m_w[0][c] = '0;
  end

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k+1] <= '0;
      end else begin
        ctrl_q[k+1] <= ctrl_q[k];
      end
    end
    for (genvar c = 0; c < 3; c++) begin : g_comp
      tun_step u_step (
        .clk_i (clk_i),
        .r_i   (r_w[k][c]),
        .a_i   (a_w[k][c]),
        .b_i   (b_w[k][c]),
        .m_i   (m_w[k][c]),
        .r_o   (r_w[k+1][c]),
        .a_o   (a_w[k+1][c]),
        .b_o   (b_w[k+1][c]),
        .m_o   (m_w[k+1][c])
      );
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (ctrl_q[NumSteps].degen) begin
        nrm_d[c] = '0;
      end else if (ctrl_q[NumSteps].neg[c]) begin
        nrm_d[c] = -OutW'(m_w[NumSteps][c]);
      end else begin
        nrm_d[c] = OutW'(m_w[NumSteps][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_q[NumSteps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q   <= nrm_d;
    degen_q <= ctrl_q[NumSteps].degen;
  end

  assign valid_o      = valid_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = degen_q;

endmodule
`default_nettype wire

// ===== rtl/core/tun_cross.sv =====
// edge vectors and exact cross product, three stages
`default_nettype none
module tun_cross import tun_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [CoordW-1:0] ax_i,
  input  wire logic signed [CoordW-1:0] ay_i,
  input  wire logic signed [CoordW-1:0] az_i,
  input  wire logic signed [CoordW-1:0] bx_i,
  input  wire logic signed [CoordW-1:0] by_i,
  input  wire logic signed [CoordW-1:0] bz_i,
  input  wire logic signed [CoordW-1:0] cx_i,
  input  wire logic signed [CoordW-1:0] cy_i,
  input  wire logic signed [CoordW-1:0] cz_i,
  output tun_ctrl_t                     ctrl_o,
  output logic [MagW-1:0]               mag_x_o,
  output logic [MagW-1:0]               mag_y_o,
  output logic [MagW-1:0]               mag_z_o
);

  logic signed [EdgeW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [CrossW-1:0] crx_d, cry_d, crz_d;
  logic [MagW-1:0] mx_q, my_q, mz_q;
  logic [2:0] neg_q;
  logic [2:0] vld_q;

  function automatic logic signed [EdgeW-1:0] sub_e(logic signed [CoordW-1:0] t,
                                                     logic signed [CoordW-1:0] f);
    return EdgeW'(t) - EdgeW'(f);
  endfunction

  function automatic logic [MagW-1:0] abs_c(logic signed [CrossW-1:0] v);
    logic signed [CrossW-1:0] n;
    n = -v;
    return v[CrossW-1] ? n[MagW-1:0] : v[MagW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_comb begin
    crx_d = CrossW'(p0_q) - CrossW'(p1_q);
    cry_d = CrossW'(p2_q) - CrossW'(p3_q);
    crz_d = CrossW'(p4_q) - CrossW'(p5_q);
  end

  always_ff @(posedge clk_i) begin
    ux_q <= sub_e(bx_i, ax_i);
    uy_q <= sub_e(by_i, ay_i);
    uz_q <= sub_e(bz_i, az_i);
    vx_q <= sub_e(cx_i, ax_i);
    vy_q <= sub_e(cy_i, ay_i);
    vz_q <= sub_e(cz_i, az_i);
    p0_q <= ProdW'(uy_q) * ProdW'(vz_q);
    p1_q <= ProdW'(uz_q) * ProdW'(vy_q);
    p2_q <= ProdW'(uz_q) * ProdW'(vx_q);
    p3_q <= ProdW'(ux_q) * ProdW'(vz_q);
    p4_q <= ProdW'(ux_q) * ProdW'(vy_q);
    p5_q <= ProdW'(uy_q) * ProdW'(vx_q);
    mx_q <= abs_c(crx_d);
    my_q <= abs_c(cry_d);
    mz_q <= abs_c(crz_d);
    neg_q <= {crz_d[CrossW-1], cry_d[CrossW-1], crx_d[CrossW-1]};
  end

  assign ctrl_o = '{valid: vld_q[2], degen: 1'b0, neg: neg_q};
  assign mag_x_o = mx_q;
  assign mag_y_o = my_q;
  assign mag_z_o = mz_q;

endmodule
`default_nettype wire

// ===== rtl/core/tun_square.sv =====
// squares, magnitude sum and start values of the digit recurrence
`default_nettype none
module tun_square import tun_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  tun_ctrl_t              ctrl_i,
  input  wire logic [MagW-1:0]   mag_i [3],
  output tun_ctrl_t              ctrl_o,
  output logic signed [AccW-1:0] r_o [3],
  output logic signed [AccW-1:0] a_o [3],
  output logic signed [AccW-1:0] b_o [3]
);

  logic [ProdW-1:0] hh_q [3];
  logic [ProdW-1:0] hl_q [3];
  logic [ProdW-1:0] ll_q [3];
  logic [SqW-1:0] sq_q [3];
  logic [SumW-1:0] sum_d;
  logic signed [AccW-1:0] r_q [3];
  logic signed [AccW-1:0] a_q [3];
  logic signed [AccW-1:0] b_q [3];
  tun_ctrl_t c1_q, c2_q, c3_q;

  assign sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else begin
      c1_q <= ctrl_i;
      c2_q <= c1_q;
      c3_q <= '{valid: c2_q.valid, degen: (sum_d == '0), neg: c2_q.neg};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      hh_q[i] <= ProdW'(mag_i[i][MagW-1:HalfW]) * ProdW'(mag_i[i][MagW-1:HalfW]);
      hl_q[i] <= ProdW'(mag_i[i][MagW-1:HalfW]) * ProdW'(mag_i[i][HalfW-1:0]);
      ll_q[i] <= ProdW'(mag_i[i][HalfW-1:0]) * ProdW'(mag_i[i][HalfW-1:0]);
      sq_q[i] <= (SqW'(hh_q[i]) << (2 * HalfW)) + (SqW'(hl_q[i]) << (HalfW + 1))
                 + SqW'(ll_q[i]);
      r_q[i] <= (AccW'(sq_q[i]) << TargetShift) - AccW'(sum_d);
      a_q[i] <= -(AccW'(sum_d) << InitAShift);
      b_q[i] <= AccW'(sum_d) << TargetShift;
    end
  end

  assign ctrl_o = c3_q;
  assign r_o = r_q;
  assign a_o = a_q;
  assign b_o = b_q;

endmodule
`default_nettype wire

// ===== rtl/core/tun_step.sv =====
// one digit of the rounded quotient, one register stage
`default_nettype none
module tun_step import tun_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic signed [AccW-1:0]   r_i,
  input  wire logic signed [AccW-1:0]   a_i,
  input  wire logic signed [AccW-1:0]   b_i,
  input  wire logic [MW-1:0]            m_i,
  output logic signed [AccW-1:0]        r_o,
  output logic signed [AccW-1:0]        a_o,
  output logic signed [AccW-1:0]        b_o,
  output logic [MW-1:0]                 m_o
);

  logic signed [AccW-1:0] cand_d, anx_d;
  logic take_d;
  logic signed [AccW-1:0] r_q, a_q, b_q;
  logic [MW-1:0] m_q;

  always_comb begin
    cand_d = r_i - a_i - b_i;
    take_d = ~cand_d[AccW-1];
    anx_d  = take_d ? (a_i + (b_i <<< 1)) : a_i;
  end

  always_ff @(posedge clk_i) begin
    r_q <= take_d ? cand_d : r_i;
    a_q <= anx_d >>> 1;
    b_q <= b_i >>> 2;
    m_q <= {m_i[MW-2:0], take_d};
  end

  assign r_o = r_q;
  assign a_o = a_q;
  assign b_o = b_q;
  assign m_o = m_q;

endmodule
`default_nettype wire

// ===== test/triangle_unit_normal_tb.sv =====
// self-checking testbench for the triangle unit normal block
`timescale 1ns / 100ps
module triangle_unit_normal_tb;
  import tun_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef struct {
    logic signed [OutW-1:0] nx;
    logic signed [OutW-1:0] ny;
    logic signed [OutW-1:0] nz;
    logic                   degen;
  } normal_t;
  typedef struct {
    coord_t  v[9];
    logic    typed;
    normal_t res;
  } face_row_t;

  localparam int WatchLimit = 4000;
  localparam int NumRandom  = 1600;
  localparam logic signed [OutW-1:0] One = 1 <<< NormalFracBits;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  coord_t face_v[9];
  logic busy_o, valid_o, degenerate_o;
  logic signed [OutW-1:0] normal_x_o, normal_y_o, normal_z_o;

  normal_t normal_q[$];
  int fail_cnt = 0;
  int idle_cycles = 0;
  logic typed_pending = 1'b0;
  normal_t typed_res;

  function automatic void queue_expected(normal_t e);
    normal_q.insert(normal_q.size(), e);
  endfunction

  always #1 clk_i = ~clk_i;

  initial for (int i = 0; i < 9; i++) face_v[i] = '0;

  triangle_unit_normal u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_x_i(face_v[0]), .first_y_i(face_v[1]), .first_z_i(face_v[2]),
    .second_x_i(face_v[3]), .second_y_i(face_v[4]), .second_z_i(face_v[5]),
    .third_x_i(face_v[6]), .third_y_i(face_v[7]), .third_z_i(face_v[8]),
    .valid_o, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  function automatic logic [255:0] mag_of(logic signed [CrossW-1:0] c);
    logic signed [CrossW-1:0] a;
    a = (c < 0) ? -c : c;
    return {{(256-CrossW){1'b0}}, a};
  endfunction

  function automatic logic [OutW-1:0] scale_comp(logic signed [CrossW-1:0] c,
                                                 logic [255:0] s);
    logic [255:0] m, target, k;
    logic [63:0] lo, hi, mid;
    m = mag_of(c);
    target = (m * m) << TargetShift;
    lo = 0;
    hi = 64'd1 << NormalFracBits;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      k = {192'd0, 2 * mid - 1};
      if (k * k * s <= target) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? OutW'(-lo) : OutW'(lo);
  endfunction

  function automatic normal_t face_normal(coord_t v[9]);
    logic signed [EdgeW-1:0] ux, uy, uz, wx, wy, wz;
    logic signed [CrossW-1:0] cx, cy, cz;
    logic [255:0] s;
    normal_t r;
    ux = v[3] - v[0]; uy = v[4] - v[1]; uz = v[5] - v[2];
    wx = v[6] - v[0]; wy = v[7] - v[1]; wz = v[8] - v[2];
    cx = uy * wz - uz * wy;
    cy = uz * wx - ux * wz;
    cz = ux * wy - uy * wx;
    s = mag_of(cx) * mag_of(cx) + mag_of(cy) * mag_of(cy) + mag_of(cz) * mag_of(cz);
    if (s == 0) begin
      r = '{0, 0, 0, 1'b1};
    end else begin
      r.nx = scale_comp(cx, s);
      r.ny = scale_comp(cy, s);
      r.nz = scale_comp(cz, s);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && start_i && !busy_o) begin
      queue_expected(typed_pending ? typed_res : face_normal(face_v));
      idle_cycles <= 0;
    end else if (valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && valid_o) begin
      if (normal_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = normal_q.pop_front();
        if (normal_x_o !== e.nx) report_mismatch("normal_x", normal_x_o, e.nx);
        if (normal_y_o !== e.ny) report_mismatch("normal_y", normal_y_o, e.ny);
        if (normal_z_o !== e.nz) report_mismatch("normal_z", normal_z_o, e.nz);
        if (degenerate_o !== e.degen) report_mismatch("degenerate", degenerate_o, e.degen);
      end
    end
    if (idle_cycles >= WatchLimit) begin
      $display("triangle_unit_normal regression: fail");
      $finish;
    end
  end

  task automatic send_face(coord_t v[9], logic typed, normal_t res);
    @(negedge clk_i);
    face_v = v;
    typed_pending = typed;
    typed_res = res;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(($urandom_range(0, 16) - 8) * 32'h10000);
      default: return coord_t'($urandom_range(0, 2047)) - 1024;
    endcase
  endfunction

  face_row_t rows[$];

  function automatic void add_row(face_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    coord_t v[9];
    normal_t z;
    int burst, mode, kind, k;
    coord_t mx, mn;
    mx = {1'b0, {(CoordW-1){1'b1}}};
    mn = {1'b1, {(CoordW-1){1'b0}}};
    z = '{0, 0, 0, 1'b0};
    add_row('{'{default: 0}, 1'b1, '{0, 0, 0, 1'b1}});
    add_row('{'{default: mx}, 1'b1, '{0, 0, 0, 1'b1}});
    add_row('{'{default: mn}, 1'b1, '{0, 0, 0, 1'b1}});
    add_row('{'{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0}, 1'b1, '{0, 0, One, 1'b0}});
    add_row('{'{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0}, 1'b1, '{0, 0, -One, 1'b0}});
    add_row('{'{0, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b1, '{One, 0, 0, 1'b0}});
    add_row('{'{0, 0, 0, 0, 0, 1, 1, 0, 0}, 1'b1, '{0, One, 0, 1'b0}});
    add_row('{'{0, 0, 0, 1, 1, 1, 2, 2, 2}, 1'b1, '{0, 0, 0, 1'b1}});
    add_row('{'{mn, mn, mn, mx, mn, mn, mn, mx, mn}, 1'b1, '{0, 0, One, 1'b0}});
    add_row('{'{mx, mx, mx, mn, mx, mx, mx, mx, mn}, 1'b1, '{0, -One, 0, 1'b0}});
    add_row('{'{mn, mx, mn, mx, mn, mx, mn, mn, mx}, 1'b0, z});
    add_row('{'{mx, mn, mx, mn, mx, mn, mx, mx, mn}, 1'b0, z});
    add_row('{'{0, 0, 0, 1, 2, 3, 4, 5, 6}, 1'b0, z});
    add_row('{'{0, 0, 0, 3, 0, 0, 0, 4, 5}, 1'b0, z});
    add_row('{'{-1, -1, -1, 1, 1, -1, -1, 1, 1}, 1'b0, z});
    add_row('{'{0, 0, 0, 1, 1, 0, 1, 0, 1}, 1'b0, z});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_face(rows[i].v, rows[i].typed, rows[i].res);

    k = 0;
    while (k < NumRandom) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && k < NumRandom; b++) begin
        kind = $urandom_range(0, 9);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < 9; i++) v[i] = rand_coord(mode);
        if (kind == 0) begin
          for (int i = 0; i < 3; i++) v[6+i] = v[i] + (v[3+i] - v[i]) * ($urandom_range(0, 4) - 2);
        end else if (kind == 1) begin
          for (int i = 0; i < 3; i++) v[3+i] = v[i];
        end else if (kind == 2) begin
          for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
        end
        send_face(v, 1'b0, z);
        k++;
        if (k == NumRandom / 2) begin
          pause_sender(1);
          while (normal_q.size() != 0) @(negedge clk_i);
        end
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    @(negedge clk_i);
    start_i = 1'b0;
    while (normal_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_cnt == 0) $display("triangle_unit_normal regression: pass");
    else $display("triangle_unit_normal regression: fail");
    $finish;
  end

endmodule
